// ----- rtl/core/qlm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlm_pkg
// Shared types and codes of the queued lock manager.
// ----------------------------------------------------------------------------
package qlm_pkg;

  localparam int ID_W        = 6;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int TABLE_DEPTH = 1 << ID_W;

  typedef logic [ID_W-1:0]     id_t;
  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam func_t FUNC_ACQUIRE = 2'd0;
  localparam func_t FUNC_TRY     = 2'd1;
  localparam func_t FUNC_RELEASE = 2'd2;

  localparam status_t ST_GRANTED = 3'd0;
  localparam status_t ST_QUEUED  = 3'd1;
  localparam status_t ST_REFUSED = 3'd2;
  localparam status_t ST_FREED   = 3'd3;
  localparam status_t ST_HANDED  = 3'd4;

  // operation classes passed from the front end to the back end
  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_TRY     = 2'd1,
    OP_RELEASE = 2'd2,
    OP_REFUSE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t op;
    id_t lock_id;
    id_t proc_id;
  } req_t;

endpackage

// ----- rtl/core/qlm_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlm_req_if
// Request channel: one beat carries function, lock and process.
// ----------------------------------------------------------------------------
interface qlm_req_if;
  import qlm_pkg::*;

  logic  valid;
  logic  ready;
  func_t func;
  id_t   lock_id;
  id_t   proc_id;

  modport source(output valid, output func, output lock_id, output proc_id, input ready);
  modport sink(input valid, input func, input lock_id, input proc_id, output ready);

endinterface

// ----- rtl/core/qlm_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlm_rsp_if
// Response channel: one beat carries status, lock and woken process.
// ----------------------------------------------------------------------------
interface qlm_rsp_if;
  import qlm_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  id_t     lock_id_out;
  id_t     woken_proc;

  modport source(output valid, output status, output lock_id_out, output woken_proc,
                 input ready);
  modport sink(input valid, input status, input lock_id_out, input woken_proc,
               output ready);

endinterface

// ----- rtl/core/qlm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlm_front
// Accepts request beats and classifies them by function and id range.
// ----------------------------------------------------------------------------
module qlm_front #(
  parameter int NUM_LOCKS = 64,
  parameter int NUM_PROCS = 64
) (
  qlm_req_if.sink         req,
  output logic            push_valid,
  input  logic            push_ready,
  output qlm_pkg::req_t   push_data
);
  import qlm_pkg::*;

  logic in_range;

  assign in_range = (int'(req.lock_id) < NUM_LOCKS) && (int'(req.proc_id) < NUM_PROCS);

  always_comb begin
    push_data.lock_id = req.lock_id;
    push_data.proc_id = req.proc_id;
    push_data.op      = OP_REFUSE;
    if (in_range) begin
      unique case (req.func)
        FUNC_ACQUIRE: push_data.op = OP_ACQUIRE;
        FUNC_TRY:     push_data.op = OP_TRY;
        FUNC_RELEASE: push_data.op = OP_RELEASE;
        default:      push_data.op = OP_REFUSE;
      endcase
    end
  end

  assign push_valid = req.valid;
  assign req.ready  = push_ready;

endmodule

// ----- rtl/core/qlm_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlm_queue
// Two-entry FIFO between front end and back end.
// ----------------------------------------------------------------------------
module qlm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  qlm_pkg::req_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output qlm_pkg::req_t pop_data
);
  import qlm_pkg::*;

  req_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/qlm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlm_back
// Executes classified requests against the lock table and wait lists.
// ----------------------------------------------------------------------------
module qlm_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  qlm_pkg::req_t pop_data,
  qlm_rsp_if.source     rsp
);
  import qlm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TAIL = 4'b0010,
    S_HEAD = 4'b0100,
    S_LINK = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  req_t   cur;
  id_t    woke;

  // per-lock and per-process flags
  logic [TABLE_DEPTH-1:0] held;
  logic [TABLE_DEPTH-1:0] qvalid;
  logic [TABLE_DEPTH-1:0] waiting;
  logic [TABLE_DEPTH-1:0] link_valid;

  // wait-list memories
  id_t head_mem [TABLE_DEPTH];
  id_t tail_mem [TABLE_DEPTH];
  id_t link_mem [TABLE_DEPTH];
  id_t head_rd;
  id_t tail_rd;
  id_t link_rd;

  logic    out_valid;
  status_t out_status;
  id_t     out_lock;
  id_t     out_woken;

  logic    out_free;
  logic    take;
  id_t     lk;
  id_t     pr;
  logic    done;
  status_t st;
  id_t     woken;
  logic    held_set, held_clr;
  logic    qv_set, qv_clr;
  logic    wait_set, wait_clr;
  logic    lv_set, lv_clr;
  logic    head_we, tail_we, link_we;
  logic    head_re, tail_re, link_re;
  id_t     head_wd;
  logic    woke_load;

  assign out_free  = !out_valid || rsp.ready;
  assign pop_ready = (state == S_IDLE) && out_free;
  assign take      = pop_ready && pop_valid;
  assign lk        = (state == S_IDLE) ? pop_data.lock_id : cur.lock_id;
  assign pr        = (state == S_IDLE) ? pop_data.proc_id : cur.proc_id;

  always_comb begin
    state_next = state;
    done       = 1'b0;
    st         = ST_REFUSED;
    woken      = '0;
    held_set   = 1'b0;
    held_clr   = 1'b0;
    qv_set     = 1'b0;
    qv_clr     = 1'b0;
    wait_set   = 1'b0;
    wait_clr   = 1'b0;
    lv_set     = 1'b0;
    lv_clr     = 1'b0;
    head_we    = 1'b0;
    tail_we    = 1'b0;
    link_we    = 1'b0;
    head_re    = 1'b0;
    tail_re    = 1'b0;
    link_re    = 1'b0;
    head_wd    = pr;
    woke_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          unique case (pop_data.op)
            OP_TRY: begin
              done = 1'b1;
              if (!held[lk]) begin
                held_set = 1'b1;
                st       = ST_GRANTED;
              end
            end
            OP_ACQUIRE: begin
              if (waiting[pr]) begin
                done = 1'b1;
              end else if (!held[lk]) begin
                done     = 1'b1;
                held_set = 1'b1;
                st       = ST_GRANTED;
              end else if (!qvalid[lk]) begin
                done     = 1'b1;
                head_we  = 1'b1;
                tail_we  = 1'b1;
                qv_set   = 1'b1;
                wait_set = 1'b1;
                st       = ST_QUEUED;
              end else begin
                tail_re    = 1'b1;
                state_next = S_TAIL;
              end
            end
            OP_RELEASE: begin
              if (qvalid[lk]) begin
                head_re    = 1'b1;
                state_next = S_HEAD;
              end else begin
                done     = 1'b1;
                held_clr = 1'b1;
                st       = ST_FREED;
              end
            end
            default: done = 1'b1;
          endcase
        end
      end
      S_TAIL: begin
        done       = 1'b1;
        link_we    = 1'b1;
        lv_set     = 1'b1;
        tail_we    = 1'b1;
        wait_set   = 1'b1;
        st         = ST_QUEUED;
        state_next = S_IDLE;
      end
      S_HEAD: begin
        woke_load = 1'b1;
        if (link_valid[head_rd]) begin
          link_re    = 1'b1;
          state_next = S_LINK;
        end else begin
          done       = 1'b1;
          qv_clr     = 1'b1;
          wait_clr   = 1'b1;
          held_set   = 1'b1;
          woken      = head_rd;
          st         = ST_HANDED;
          state_next = S_IDLE;
        end
      end
      S_LINK: begin
        done       = 1'b1;
        head_we    = 1'b1;
        head_wd    = link_rd;
        wait_clr   = 1'b1;
        lv_clr     = 1'b1;
        held_set   = 1'b1;
        woken      = woke;
        st         = ST_HANDED;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[lk] <= head_wd;
    end
    if (head_re) begin
      head_rd <= head_mem[lk];
    end
  end

  always_ff @(posedge clk) begin
    if (tail_we) begin
      tail_mem[lk] <= pr;
    end
    if (tail_re) begin
      tail_rd <= tail_mem[lk];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[tail_rd] <= pr;
    end
    if (link_re) begin
      link_rd <= link_mem[head_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= pop_data;
    end
    if (woke_load) begin
      woke <= head_rd;
    end
    if (done) begin
      out_status <= st;
      out_lock   <= lk;
      out_woken  <= woken;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      held       <= '0;
      qvalid     <= '0;
      waiting    <= '0;
      link_valid <= '0;
    end else begin
      state <= state_next;
      if (done) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (held_set) begin
        held[lk] <= 1'b1;
      end
      if (held_clr) begin
        held[lk] <= 1'b0;
      end
      if (qv_set) begin
        qvalid[lk] <= 1'b1;
      end
      if (qv_clr) begin
        qvalid[lk] <= 1'b0;
      end
      if (wait_set) begin
        waiting[pr] <= 1'b1;
      end
      if (wait_clr) begin
        waiting[woken] <= 1'b0;
      end
      if (lv_set) begin
        link_valid[tail_rd] <= 1'b1;
      end
      if (lv_clr) begin
        link_valid[woken] <= 1'b0;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.lock_id_out = out_lock;
  assign rsp.woken_proc  = out_woken;

endmodule

// ----- rtl/core/queued_lock_manager_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queued_lock_manager_core
// Table of FIFO-queued mutexes with acquire, try-acquire and release.
// ----------------------------------------------------------------------------
// Each request beat gives one response beat, in order. A grant, refusal,
// free or first waiter completes in the idle state of the back end;
// queuing behind an existing waiter adds a tail read; a handoff adds a head
// read and a link read if the woken waiter has a successor. The wait lists
// live in three 64-entry single-port memories (head, tail, next link);
// lock, queue and waiting flags are flops cleared by reset, so no clearing
// pass is needed. A two-beat queue decouples request intake from execution.
// ----------------------------------------------------------------------------
module queued_lock_manager_core #(
  parameter int NUM_LOCKS = 64,
  parameter int NUM_PROCS = 64
) (
  input logic       clk,
  input logic       rst,
  qlm_req_if.sink   req,
  qlm_rsp_if.source rsp
);
  import qlm_pkg::*;

  logic push_valid;
  logic push_ready;
  req_t push_data;
  logic pop_valid;
  logic pop_ready;
  req_t pop_data;

  qlm_front #(
    .NUM_LOCKS(NUM_LOCKS),
    .NUM_PROCS(NUM_PROCS)
  ) u_front (
    .req       (req),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  qlm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  qlm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .rsp      (rsp)
  );

endmodule
